[rtl/pwap_pkg.sv]
// Shared constants, types and state codes of the power window average and peak unit.
package pwap_pkg;

  localparam int WINDOW     = 64;
  localparam int IN_POWER_W = 16;
  localparam int POWER_W    = 17;
  localparam int STATUS_W   = 8;
  localparam int CFG_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int SLOT_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int COUNT_W    = $clog2(WINDOW + 1);
  localparam int SUM_W      = POWER_W + $clog2(WINDOW);
  localparam int DIVCNT_W   = $clog2(SUM_W + 1);
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = 1;
  localparam int QCNT_W     = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_VALID_CODE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UNINIT_CODE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOO_SMALL_MASK = 2'd2;

  typedef struct packed {
    logic [POWER_W-1:0]  power;
    logic [STATUS_W-1:0] status;
    logic                valid;
  } sample_t;

  typedef struct packed {
    logic               valid;
    logic [POWER_W-1:0] power;
  } ring_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  typedef struct packed {
    logic pop;
    logic upd;
    logic step;
    logic ld;
  } back_ctl_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_UPDATE,
    BK_DIV,
    BK_OUT
  } back_state_t;

endpackage

[rtl/power_window_average_peak_unit.sv]
// Top level of the power window average and peak unit.
//
// Each input word carries two power readings with their status bytes. The
// unit sums the powers and ORs the statuses into a current sample, stores it
// in a ring of WINDOW entries and reports, per word, the current sample, the
// truncated mean of the valid samples held in the ring (held when none is
// valid), and a sticky all-time peak. One result word follows every input
// word. The bit-serial divider that forms the average yields one quotient
// bit per cycle over the SUM_W dividend bits (23 for a window of 64) and is
// skipped when no valid sample is held. A two-entry queue sits between the
// input side and the processing side, so up to two further words are taken
// while one is being worked on, and a finished result waits in the output
// register. Configuration registers (index: valid_code 0, uninit_code 1,
// too_small_mask 2) are written through cfg_we, cfg_index and cfg_wdata and
// should only change while the unit is idle. Ring contents need no clearing
// after reset because an entry is read only once the ring has wrapped.
module power_window_average_peak_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [pwap_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pwap_pkg::CFG_W-1:0]        cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [pwap_pkg::IN_POWER_W-1:0]   in_encl_power,
  input  logic [pwap_pkg::STATUS_W-1:0]     in_encl_status,
  input  logic [pwap_pkg::IN_POWER_W-1:0]   in_sps_power,
  input  logic [pwap_pkg::STATUS_W-1:0]     in_sps_status,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [pwap_pkg::POWER_W-1:0]      out_current_power,
  output logic [pwap_pkg::STATUS_W-1:0]     out_current_status,
  output logic [pwap_pkg::POWER_W-1:0]      out_average_power,
  output logic [pwap_pkg::STATUS_W-1:0]     out_average_status,
  output logic [pwap_pkg::POWER_W-1:0]      out_peak_power,
  output logic [pwap_pkg::STATUS_W-1:0]     out_peak_status
);

  logic [pwap_pkg::STATUS_W-1:0] valid_code_r, uninit_code_r, too_small_mask_r;
  logic                          push;
  logic                          pop;
  pwap_pkg::sample_t             push_sample;
  pwap_pkg::sample_t             pop_sample;
  pwap_pkg::queue_stat_t         q_stat;

  // Configuration registers. Writes to an index beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_code_r     <= 8'd1;
      uninit_code_r    <= 8'd0;
      too_small_mask_r <= 8'd2;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pwap_pkg::CFG_VALID_CODE:     valid_code_r     <= cfg_wdata;
        pwap_pkg::CFG_UNINIT_CODE:    uninit_code_r    <= cfg_wdata;
        pwap_pkg::CFG_TOO_SMALL_MASK: too_small_mask_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // The front end builds the sample and decides its validity on acceptance.
  pwap_front u_front (
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_encl_power  (in_encl_power),
    .in_encl_status (in_encl_status),
    .in_sps_power   (in_sps_power),
    .in_sps_status  (in_sps_status),
    .valid_code     (valid_code_r),
    .q_stat         (q_stat),
    .push           (push),
    .push_sample    (push_sample)
  );

  pwap_queue u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .push_sample (push_sample),
    .pop         (pop),
    .pop_sample  (pop_sample),
    .q_stat      (q_stat)
  );

  // The back end updates the ring and running totals, divides, and presents
  // the result word.
  pwap_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_stat             (q_stat),
    .pop_sample         (pop_sample),
    .pop                (pop),
    .valid_code         (valid_code_r),
    .uninit_code        (uninit_code_r),
    .too_small_mask     (too_small_mask_r),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_current_power  (out_current_power),
    .out_current_status (out_current_status),
    .out_average_power  (out_average_power),
    .out_average_status (out_average_status),
    .out_peak_power     (out_peak_power),
    .out_peak_status    (out_peak_status)
  );

endmodule

[rtl/pwap_front.sv]
// Front end: accepts input words and turns them into classified samples.
module pwap_front (
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [pwap_pkg::IN_POWER_W-1:0]   in_encl_power,
  input  logic [pwap_pkg::STATUS_W-1:0]     in_encl_status,
  input  logic [pwap_pkg::IN_POWER_W-1:0]   in_sps_power,
  input  logic [pwap_pkg::STATUS_W-1:0]     in_sps_status,
  input  logic [pwap_pkg::STATUS_W-1:0]     valid_code,
  input  pwap_pkg::queue_stat_t             q_stat,
  output logic                              push,
  output pwap_pkg::sample_t                 push_sample
);

  logic [pwap_pkg::STATUS_W-1:0] cur_status;

  assign in_stall   = q_stat.full;
  assign push       = in_valid && !q_stat.full;
  assign cur_status = in_encl_status | in_sps_status;

  always_comb begin
    push_sample.power  = pwap_pkg::POWER_W'(in_encl_power) + pwap_pkg::POWER_W'(in_sps_power);
    push_sample.status = cur_status;
    // Validity is fixed here and travels with the sample.
    push_sample.valid  = (cur_status == valid_code);
  end

endmodule

[rtl/pwap_queue.sv]
// Short sample queue between the front end and the back end.
module pwap_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  pwap_pkg::sample_t     push_sample,
  input  logic                  pop,
  output pwap_pkg::sample_t     pop_sample,
  output pwap_pkg::queue_stat_t q_stat
);

  pwap_pkg::sample_t              q_mem_r [pwap_pkg::QDEPTH];
  logic [pwap_pkg::QPTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [pwap_pkg::QPTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [pwap_pkg::QCNT_W-1:0]    cnt_r, cnt_nxt;

  assign q_stat.full  = (cnt_r == pwap_pkg::QCNT_W'(pwap_pkg::QDEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign pop_sample   = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + ((push) ? 1'b1 : 1'b0);
    rd_ptr_nxt = rd_ptr_r + ((pop) ? 1'b1 : 1'b0);
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= push_sample;
    end
  end

endmodule

[rtl/pwap_back.sv]
// Back end: sample ring, running sum and count, serial divider, peak hold and output register.
module pwap_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  pwap_pkg::queue_stat_t             q_stat,
  input  pwap_pkg::sample_t                 pop_sample,
  output logic                              pop,
  input  logic [pwap_pkg::STATUS_W-1:0]     valid_code,
  input  logic [pwap_pkg::STATUS_W-1:0]     uninit_code,
  input  logic [pwap_pkg::STATUS_W-1:0]     too_small_mask,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [pwap_pkg::POWER_W-1:0]      out_current_power,
  output logic [pwap_pkg::STATUS_W-1:0]     out_current_status,
  output logic [pwap_pkg::POWER_W-1:0]      out_average_power,
  output logic [pwap_pkg::STATUS_W-1:0]     out_average_status,
  output logic [pwap_pkg::POWER_W-1:0]      out_peak_power,
  output logic [pwap_pkg::STATUS_W-1:0]     out_peak_status
);

  pwap_pkg::back_state_t state_r, state_nxt;
  pwap_pkg::back_ctl_t   ctl;

  pwap_pkg::ring_entry_t ring_mem [pwap_pkg::WINDOW];
  pwap_pkg::ring_entry_t rd_entry_r;
  pwap_pkg::sample_t     cur_r;

  logic [pwap_pkg::SLOT_W-1:0]   slot_r, slot_nxt;
  logic [pwap_pkg::COUNT_W-1:0]  filled_r, filled_nxt;
  logic [pwap_pkg::SUM_W-1:0]    sum_r, sum_nxt;
  logic [pwap_pkg::COUNT_W-1:0]  count_r, count_nxt;
  logic [pwap_pkg::POWER_W-1:0]  held_avg_r;
  logic [pwap_pkg::POWER_W-1:0]  peak_r;
  logic [pwap_pkg::STATUS_W-1:0] peak_status_r;
  logic                          ring_full;
  logic                          evict;

  logic [pwap_pkg::SUM_W-1:0]    dq_r, dq_nxt;
  logic [pwap_pkg::COUNT_W-1:0]  rem_r, rem_nxt;
  logic [pwap_pkg::DIVCNT_W-1:0] div_cnt_r;
  logic [pwap_pkg::COUNT_W:0]    trial;
  logic                          trial_ge;
  logic                          div_last;

  logic                          out_valid_r;
  logic [pwap_pkg::POWER_W-1:0]  out_cur_p_r, out_avg_p_r, out_peak_p_r;
  logic [pwap_pkg::STATUS_W-1:0] out_cur_s_r, out_avg_s_r, out_peak_s_r;
  logic [pwap_pkg::STATUS_W-1:0] avg_status;

  assign ring_full = (filled_r == pwap_pkg::COUNT_W'(pwap_pkg::WINDOW));
  assign evict     = ring_full && rd_entry_r.valid && (count_r != '0);
  assign div_last  = (div_cnt_r == '0);

  // Running sum and count after this sample replaces the oldest one.
  always_comb begin
    sum_nxt   = sum_r;
    count_nxt = count_r;
    if (evict) begin
      sum_nxt   = sum_nxt - pwap_pkg::SUM_W'(rd_entry_r.power);
      count_nxt = count_nxt - 1'b1;
    end
    if (cur_r.valid) begin
      sum_nxt   = sum_nxt + pwap_pkg::SUM_W'(cur_r.power);
      count_nxt = count_nxt + 1'b1;
    end
    slot_nxt   = (slot_r == pwap_pkg::SLOT_W'(pwap_pkg::WINDOW - 1)) ? '0 : slot_r + 1'b1;
    filled_nxt = ring_full ? filled_r : filled_r + 1'b1;
  end

  // One restoring division step per cycle: quotient bits shift into dq_r.
  always_comb begin
    trial    = {rem_r, dq_r[pwap_pkg::SUM_W-1]};
    trial_ge = (trial >= {1'b0, count_r});
    rem_nxt  = trial_ge ? pwap_pkg::COUNT_W'(trial - {1'b0, count_r})
                        : pwap_pkg::COUNT_W'(trial);
    dq_nxt   = {dq_r[pwap_pkg::SUM_W-2:0], trial_ge};
  end

  always_comb begin
    avg_status = uninit_code;
    if (count_r != '0) begin
      avg_status = valid_code;
      if (count_r < pwap_pkg::COUNT_W'(pwap_pkg::WINDOW)) begin
        avg_status = valid_code | too_small_mask;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pwap_pkg::BK_IDLE: begin
        if (!q_stat.empty) begin
          state_nxt = pwap_pkg::BK_UPDATE;
        end
      end
      pwap_pkg::BK_UPDATE: begin
        state_nxt = (count_nxt != '0) ? pwap_pkg::BK_DIV : pwap_pkg::BK_OUT;
      end
      pwap_pkg::BK_DIV: begin
        if (div_last) begin
          state_nxt = pwap_pkg::BK_OUT;
        end
      end
      pwap_pkg::BK_OUT: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = pwap_pkg::BK_IDLE;
        end
      end
      default: state_nxt = pwap_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    unique case (state_r)
      pwap_pkg::BK_IDLE:   ctl.pop  = !q_stat.empty;
      pwap_pkg::BK_UPDATE: ctl.upd  = 1'b1;
      pwap_pkg::BK_DIV:    ctl.step = 1'b1;
      pwap_pkg::BK_OUT:    ctl.ld   = !out_valid_r || !out_stall;
      default:             ctl      = '0;
    endcase
  end

  assign pop = ctl.pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= pwap_pkg::BK_IDLE;
      slot_r        <= '0;
      filled_r      <= '0;
      sum_r         <= '0;
      count_r       <= '0;
      held_avg_r    <= '0;
      peak_r        <= '0;
      peak_status_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ctl.upd) begin
        slot_r   <= slot_nxt;
        filled_r <= filled_nxt;
        sum_r    <= sum_nxt;
        count_r  <= count_nxt;
        if (cur_r.valid && (cur_r.power > peak_r)) begin
          peak_r        <= cur_r.power;
          peak_status_r <= valid_code;
        end
      end
      if (ctl.step && div_last) begin
        held_avg_r <= dq_nxt[pwap_pkg::POWER_W-1:0];
      end
      if (ctl.ld) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk) begin
    if (ctl.pop) begin
      cur_r      <= pop_sample;
      rd_entry_r <= ring_mem[slot_r];
    end
    if (ctl.upd) begin
      ring_mem[slot_r] <= '{valid: cur_r.valid, power: cur_r.power};
      dq_r             <= sum_nxt;
      rem_r            <= '0;
      div_cnt_r        <= pwap_pkg::DIVCNT_W'(pwap_pkg::SUM_W - 1);
    end
    if (ctl.step) begin
      dq_r      <= dq_nxt;
      rem_r     <= rem_nxt;
      div_cnt_r <= div_cnt_r - 1'b1;
    end
    if (ctl.ld) begin
      out_cur_p_r  <= cur_r.power;
      out_cur_s_r  <= cur_r.status;
      out_avg_p_r  <= held_avg_r;
      out_avg_s_r  <= avg_status;
      out_peak_p_r <= peak_r;
      out_peak_s_r <= peak_status_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_current_power  = out_cur_p_r;
  assign out_current_status = out_cur_s_r;
  assign out_average_power  = out_avg_p_r;
  assign out_average_status = out_avg_s_r;
  assign out_peak_power     = out_peak_p_r;
  assign out_peak_status    = out_peak_s_r;

endmodule

[tb/tb_power_window_average_peak_unit.sv]
// Self-checking testbench for the power window average and peak unit.
module tb_power_window_average_peak_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import pwap_pkg::*;

  // Longest stretch with no word accepted on either side and no register
  // write. The one deliberate receiver hold-off of HOLD_OFF_CYCLES is the
  // longest quiet stretch of a correct run, so the limit sits well above it.
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int QUIET_LIMIT     = 2000;
  localparam int RANDOM_PHASES   = 12;

  // One result word as the block reports it.
  typedef struct packed {
    logic [POWER_W-1:0]  cur_p;
    logic [STATUS_W-1:0] cur_s;
    logic [POWER_W-1:0]  avg_p;
    logic [STATUS_W-1:0] avg_s;
    logic [POWER_W-1:0]  peak_p;
    logic [STATUS_W-1:0] peak_s;
  } power_report_t;

  // One row of the directed table. A row is either a register write or an
  // input word. A word row may carry a hand-written result.
  typedef struct {
    bit                    is_cfg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_W-1:0]      data;
    logic [IN_POWER_W-1:0] ep;
    logic [STATUS_W-1:0]   es;
    logic [IN_POWER_W-1:0] sp;
    logic [STATUS_W-1:0]   ss;
    bit                    typed;
    power_report_t         want;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]      cfg_wdata;
  logic                  in_valid;
  logic                  in_stall;
  logic [IN_POWER_W-1:0] in_encl_power;
  logic [STATUS_W-1:0]   in_encl_status;
  logic [IN_POWER_W-1:0] in_sps_power;
  logic [STATUS_W-1:0]   in_sps_status;
  logic                  out_valid;
  logic                  out_stall;
  logic [POWER_W-1:0]    out_current_power;
  logic [STATUS_W-1:0]   out_current_status;
  logic [POWER_W-1:0]    out_average_power;
  logic [STATUS_W-1:0]   out_average_status;
  logic [POWER_W-1:0]    out_peak_power;
  logic [STATUS_W-1:0]   out_peak_status;

  power_window_average_peak_unit DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_encl_power      (in_encl_power),
    .in_encl_status     (in_encl_status),
    .in_sps_power       (in_sps_power),
    .in_sps_status      (in_sps_status),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_current_power  (out_current_power),
    .out_current_status (out_current_status),
    .out_average_power  (out_average_power),
    .out_average_status (out_average_status),
    .out_peak_power     (out_peak_power),
    .out_peak_status    (out_peak_status)
  );

  always #5 clk = ~clk;

  // Expected result words, oldest first.
  power_report_t pending_reports[$];
  int            mismatches   = 0;
  int            quiet_cycles = 0;
  bit            gaps_on      = 1'b1;
  bit            hold_off_req = 1'b0;

  // Our own copy of the register file, at its reset values.
  logic [STATUS_W-1:0] valid_code_m = 8'd1;
  logic [STATUS_W-1:0] uninit_m     = 8'd0;
  logic [STATUS_W-1:0] too_small_m  = 8'd2;

  // Our own copy of the window state. The ring needs no clearing: a slot
  // is read for eviction only after the window has wrapped once.
  logic [POWER_W-1:0]  ring_pwr [WINDOW];
  bit                  ring_ok  [WINDOW];
  logic [SLOT_W-1:0]   slot_m    = '0;
  logic [COUNT_W-1:0]  filled_m  = '0;
  logic [SUM_W-1:0]    sum_m     = '0;
  logic [COUNT_W-1:0]  count_m   = '0;
  logic [POWER_W-1:0]  held_m    = '0;
  logic [POWER_W-1:0]  peak_m    = '0;
  logic [STATUS_W-1:0] peak_st_m = '0;

  // Works out the result of one accepted input word and advances the
  // window state. Validity is decided once, when the sample is written,
  // and is kept with the slot. On eviction, that kept bit decides whether
  // the sample leaves the running sum, whatever the valid code is by then.
  function automatic power_report_t predict_power_report(
    input logic [IN_POWER_W-1:0] ep,
    input logic [STATUS_W-1:0]   es,
    input logic [IN_POWER_W-1:0] sp,
    input logic [STATUS_W-1:0]   ss
  );
    power_report_t       r;
    logic [POWER_W-1:0]  sample_p;
    logic [STATUS_W-1:0] sample_s;
    logic [SUM_W-1:0]    quot;
    bit                  sample_ok;
    sample_p  = {1'b0, ep} + {1'b0, sp};
    sample_s  = es | ss;
    sample_ok = (sample_s == valid_code_m);
    if (filled_m >= COUNT_W'(WINDOW)) begin
      if (ring_ok[slot_m] && count_m != '0) begin
        sum_m   = sum_m - SUM_W'(ring_pwr[slot_m]);
        count_m = count_m - 1'b1;
      end
    end else begin
      filled_m = filled_m + 1'b1;
    end
    ring_pwr[slot_m] = sample_p;
    ring_ok[slot_m]  = sample_ok;
    if (sample_ok) begin
      sum_m   = sum_m + SUM_W'(sample_p);
      count_m = count_m + 1'b1;
      // A sample equal to the peak leaves it and its status alone.
      if (sample_p > peak_m) begin
        peak_m    = sample_p;
        peak_st_m = valid_code_m;
      end
    end
    // With no valid sample in the window, the last average is repeated.
    if (count_m != '0) begin
      quot    = sum_m / SUM_W'(count_m);
      held_m  = quot[POWER_W-1:0];
      r.avg_s = valid_code_m;
      if (count_m < COUNT_W'(WINDOW)) begin
        r.avg_s = r.avg_s | too_small_m;
      end
    end else begin
      r.avg_s = uninit_m;
    end
    slot_m   = (slot_m == SLOT_W'(WINDOW - 1)) ? '0 : slot_m + 1'b1;
    r.cur_p  = sample_p;
    r.cur_s  = sample_s;
    r.avg_p  = held_m;
    r.peak_p = peak_m;
    r.peak_s = peak_st_m;
    return r;
  endfunction

  task automatic report(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  task automatic check_field(input string what, input int got, input int want);
    if (got != want) begin
      report(what, got, want);
    end
  endtask

  // The result side. A word moves when out_valid is high and out_stall is
  // low at the edge. Both are sampled before the edge updates them.
  always @(posedge clk) begin
    power_report_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_reports.size() == 0) begin
        report("result word with nothing expected", int'(out_current_power), 0);
      end else begin
        want = pending_reports.pop_front();
        check_field("current_power", int'(out_current_power), int'(want.cur_p));
        check_field("current_status", int'(out_current_status), int'(want.cur_s));
        check_field("average_power", int'(out_average_power), int'(want.avg_p));
        check_field("average_status", int'(out_average_status), int'(want.avg_s));
        check_field("peak_power", int'(out_peak_power), int'(want.peak_p));
        check_field("peak_status", int'(out_peak_status), int'(want.peak_s));
      end
    end
  end

  // Watchdog. A run that stops making progress ends here.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver. It stalls in short random bursts. Once, on request, it holds
  // off for a long stretch while the sender keeps offering words. The input
  // queue then fills up and the block has to stall its input side.
  initial begin : receiver
    int n;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        n = $urandom_range(1, 8);
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Sends one word. The task is entered in the time step of a rising edge,
  // and it returns in the time step of the edge that accepted the word. At
  // that point the next call may keep in_valid high with a new payload, or
  // drop it for a gap. Either way, in_valid gets only one assignment in that
  // step. The expectation is formed on acceptance, in acceptance order.
  task automatic send_word(
    input logic [IN_POWER_W-1:0] ep,
    input logic [STATUS_W-1:0]   es,
    input logic [IN_POWER_W-1:0] sp,
    input logic [STATUS_W-1:0]   ss,
    input bit                    typed,
    input power_report_t         want
  );
    power_report_t predicted;
    int            gap;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 8);
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_encl_power  <= ep;
    in_encl_status <= es;
    in_sps_power   <= sp;
    in_sps_status  <= ss;
    do begin
      @(posedge clk);
    end while (in_stall);
    predicted = predict_power_report(ep, es, sp, ss);
    pending_reports.push_back(typed ? want : predicted);
  endtask

  // Register writes wait until every word sent so far has come back. Every
  // word yields exactly one result, so the block is idle by then. After a
  // write, cfg_we is lowered and the task waits before it returns, so that
  // cfg_we is never lowered and raised in the same step.
  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_VALID_CODE:     valid_code_m = data;
      CFG_UNINIT_CODE:    uninit_m     = data;
      CFG_TOO_SMALL_MASK: too_small_m  = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic stim_row_t word_row(
    input logic [IN_POWER_W-1:0] ep,
    input logic [STATUS_W-1:0]   es,
    input logic [IN_POWER_W-1:0] sp,
    input logic [STATUS_W-1:0]   ss
  );
    stim_row_t r;
    r        = '{default: '0};
    r.ep     = ep;
    r.es     = es;
    r.sp     = sp;
    r.ss     = ss;
    return r;
  endfunction

  function automatic stim_row_t known_row(
    input logic [IN_POWER_W-1:0] ep,
    input logic [STATUS_W-1:0]   es,
    input logic [IN_POWER_W-1:0] sp,
    input logic [STATUS_W-1:0]   ss,
    input power_report_t         want
  );
    stim_row_t r;
    r       = word_row(ep, es, sp, ss);
    r.typed = 1'b1;
    r.want  = want;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_W-1:0] data);
    stim_row_t r;
    r        = '{default: '0};
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.data   = data;
    return r;
  endfunction

  // Register values lean on the extremes and on the reset value.
  function automatic logic [CFG_W-1:0] pick_code();
    case ($urandom_range(0, 3))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h01;
      default: return CFG_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Powers lean on zero, full scale and small values.
  function automatic logic [IN_POWER_W-1:0] pick_power();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return IN_POWER_W'($urandom_range(0, 15));
      default: return IN_POWER_W'($urandom_range(0, 65535));
    endcase
  endfunction

  initial begin : stimulus
    stim_row_t             tab[$];
    logic [IN_POWER_W-1:0] ep;
    logic [IN_POWER_W-1:0] sp;
    logic [STATUS_W-1:0]   es;
    logic [STATUS_W-1:0]   ss;
    int                    valid_pct;
    int                    count;
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_index      <= '0;
    cfg_wdata      <= '0;
    in_valid       <= 1'b0;
    in_encl_power  <= '0;
    in_encl_status <= '0;
    in_sps_power   <= '0;
    in_sps_status  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, starting from the reset register values (valid code 1,
    // uninit code 0, too-small mask 2). The first rows have results that
    // can be read off directly. First comes a word with nothing valid held.
    // Then a full-scale valid word, a valid word of zero power, and a word
    // equal to the peak. All later rows go through the predictor.
    tab.push_back(known_row(16'h0000, 8'h00, 16'h0000, 8'h00,
                            '{17'd0, 8'h00, 17'd0, 8'h00, 17'd0, 8'h00}));
    tab.push_back(known_row(16'hFFFF, 8'h00, 16'hFFFF, 8'h01,
                            '{17'd131070, 8'h01, 17'd131070, 8'h03, 17'd131070, 8'h01}));
    tab.push_back(known_row(16'h0000, 8'h01, 16'h0000, 8'h00,
                            '{17'd0, 8'h01, 17'd65535, 8'h03, 17'd131070, 8'h01}));
    tab.push_back(known_row(16'hFFFF, 8'h01, 16'hFFFF, 8'h01,
                            '{17'd131070, 8'h01, 17'd87380, 8'h03, 17'd131070, 8'h01}));
    // Every status bit set, and alternating bit patterns on both powers.
    tab.push_back(word_row(16'h1234, 8'hFF, 16'h0000, 8'hFF));
    tab.push_back(word_row(16'hAAAA, 8'hAA, 16'h5555, 8'h55));
    tab.push_back(word_row(16'h5555, 8'h55, 16'hAAAA, 8'hAA));
    tab.push_back(word_row(16'h0001, 8'h01, 16'h0000, 8'h00));
    // The valid code changes while samples are held. The held samples keep
    // the validity they had when they were written.
    tab.push_back(cfg_row(CFG_VALID_CODE, 8'hFF));
    tab.push_back(word_row(16'h0100, 8'hF0, 16'h0200, 8'h0F));
    tab.push_back(cfg_row(CFG_TOO_SMALL_MASK, 8'h00));
    // This word is valid under the new code and equal to the peak. The peak
    // status must stay at the old code.
    tab.push_back(word_row(16'hFFFF, 8'hFF, 16'hFFFF, 8'hFF));
    tab.push_back(cfg_row(CFG_UNINIT_CODE, 8'hFF));
    tab.push_back(cfg_row(CFG_TOO_SMALL_MASK, 8'hFF));
    tab.push_back(word_row(16'h8000, 8'h80, 16'h8000, 8'h00));
    // A valid code of zero: only words with both statuses clear count.
    tab.push_back(cfg_row(CFG_VALID_CODE, 8'h00));
    tab.push_back(word_row(16'h0007, 8'h00, 16'h0000, 8'h00));
    tab.push_back(word_row(16'h0000, 8'h00, 16'h0000, 8'h00));
    tab.push_back(cfg_row(CFG_VALID_CODE, 8'h01));
    tab.push_back(cfg_row(CFG_UNINIT_CODE, 8'h00));
    tab.push_back(cfg_row(CFG_TOO_SMALL_MASK, 8'h02));
    tab.push_back(word_row(16'h7FFF, 8'h01, 16'h0000, 8'h00));

    foreach (tab[i]) begin
      if (tab[i].is_cfg) begin
        write_cfg(tab[i].idx, tab[i].data);
      end else begin
        send_word(tab[i].ep, tab[i].es, tab[i].sp, tab[i].ss, tab[i].typed, tab[i].want);
      end
    end

    // Random part. Each phase writes all three registers and then sends a
    // run of words at its own share of valid samples: mostly valid, mixed,
    // none valid, or sparse. Every phase is longer than the window, so the
    // ring wraps and evicts in each one. The phase with no valid words
    // drains the window and exercises the held average. The last two phases
    // run without idle gaps on either side.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == RANDOM_PHASES - 2) begin
        gaps_on = 1'b0;
      end
      write_cfg(CFG_VALID_CODE, pick_code());
      write_cfg(CFG_UNINIT_CODE, pick_code());
      write_cfg(CFG_TOO_SMALL_MASK, pick_code());
      if (p == 1) begin
        hold_off_req = 1'b1;
      end
      case (p % 4)
        0:       valid_pct = 90;
        1:       valid_pct = 50;
        2:       valid_pct = 0;
        default: valid_pct = 10;
      endcase
      count = $urandom_range(130, 170);
      for (int k = 0; k < count; k++) begin
        ep = pick_power();
        sp = pick_power();
        if ($urandom_range(0, 99) < valid_pct) begin
          // Split the valid code's bits over both statuses, so that their OR
          // gives the valid code exactly.
          es = valid_code_m & STATUS_W'($urandom_range(0, 255));
          ss = (valid_code_m & ~es) | (valid_code_m & STATUS_W'($urandom_range(0, 255)));
        end else begin
          es = STATUS_W'($urandom_range(0, 255));
          ss = STATUS_W'($urandom_range(0, 255));
          if (valid_pct == 0 && (es | ss) == valid_code_m) begin
            es = (valid_code_m == 8'h00) ? 8'h01 : 8'h00;
            ss = 8'h00;
          end
        end
        send_word(ep, es, sp, ss, 1'b0, '0);
      end
    end

    // Let every result come back. Then allow a margin longer than the time a
    // word takes, so that a stray extra word would still show up.
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (pending_reports.size() != 0) begin
      report("results never received", 0, pending_reports.size());
    end
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
